### hw/rtl/imu_avg_pkg.sv
// ----------------------------------------------------------------------------
// imu_avg_pkg
// shared widths, codes and handshake structs for the imu sample averager
// ----------------------------------------------------------------------------
package imu_avg_pkg;

	localparam int SMP_W   = 16;
	localparam int SUM_W   = 24;
	localparam int CNT_W   = 8;
	localparam int LVL_W   = 11;
	localparam int TIME_W  = 5;
	localparam int SPAN_W  = 13;
	localparam int ID_W    = 16;
	localparam int REQ_W   = 2;
	localparam int IN_W    = 128;
	localparam int OUT_W   = 80;
	localparam int LANES   = 7;
	localparam int LANE_W  = 3;
	localparam int AXES    = 3;
	localparam int AXIS_W  = 2;
	localparam int SENSORS = 3;
	localparam int SENS_W  = 2;

	localparam logic [TIME_W-1:0] TIME_RESET = 5'd10;

	localparam logic signed [SMP_W-1:0] GYRO_HI = 16'sd32000;
	localparam logic signed [SMP_W-1:0] GYRO_LO = -16'sd32000;

	// lanes: accel x/y/z, temperature, gyro x/y/z
	localparam logic [LANE_W-1:0] LANE_ACC  = 3'd0;
	localparam logic [LANE_W-1:0] LANE_TEMP = 3'd3;
	localparam logic [LANE_W-1:0] LANE_GYR  = 3'd4;
	localparam logic [LANE_W-1:0] LANE_LAST = 3'd6;

	localparam logic [SENS_W-1:0] SENS_ACC  = 2'd0;
	localparam logic [SENS_W-1:0] SENS_GYR  = 2'd1;
	localparam logic [SENS_W-1:0] SENS_TEMP = 2'd2;

	typedef enum logic [REQ_W-1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_ACC    = 2'd1,
		REQ_GYR    = 2'd2,
		REQ_TEMP   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_ACCUM = 2'd1,
		ST_DIV   = 2'd2,
		ST_OUT   = 2'd3
	} state_t;

	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] dividend;
		logic [CNT_W-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [SMP_W-1:0] quotient;
	} div_rsp_t;

endpackage

### hw/rtl/imu_sample_averager_core.sv
// ----------------------------------------------------------------------------
// imu_sample_averager_core
// per-sensor boxcar averager; a taken sample is latched, then its seven lanes go
// through one adder in turn, a dropped sample is not added; readout: the axes
// pass the shared divider in turn and the result is registered, three axes for
// accel or gyro and one for temperature; an empty readout gives zero fields;
// asynchronous active-low reset clears sums, counts, ids and sets period to 10
// ----------------------------------------------------------------------------
module imu_sample_averager_core #(
	parameter int unsigned MAX_COUNT = 255
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// fifo_level, read_ok, acc_x, acc_y, acc_z, temp_raw, gyr_x, gyr_y, gyr_z
	input  logic [imu_avg_pkg::IN_W-1:0]        s_tdata,
	// req_type
	input  logic [imu_avg_pkg::REQ_W-1:0]       s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// avg_x, avg_y, avg_z, span_ms, seq_id
	output logic [imu_avg_pkg::OUT_W-1:0]       m_tdata,
	// avail
	output logic                                m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [imu_avg_pkg::TIME_W-1:0]      cfg_data
);
	import imu_avg_pkg::*;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COUNT);

	state_t state_q, state_d;

	logic [TIME_W-1:0]       time_q;
	logic [LVL_W-1:0]        last_lvl_q;
	logic signed [SMP_W-1:0] last_good_q [AXES];
	logic [CNT_W-1:0]        cnt_q [SENSORS];
	logic [ID_W-1:0]         ids_q [SENSORS];
	logic signed [SUM_W-1:0] sum_q [LANES];
	logic signed [SMP_W-1:0] val_q [LANES];
	logic [LANES-1:0]        add_en_q;
	logic [LANE_W-1:0]       lane_q;

	logic [CNT_W-1:0]        div_cnt_q;
	logic [SPAN_W-1:0]       span_q;
	logic [ID_W-1:0]         seq_q;
	logic [AXIS_W-1:0]       axis_q;
	logic [AXIS_W-1:0]       last_axis_q;
	logic [LANE_W-1:0]       base_q;
	logic                    issued_q;
	logic [SMP_W-1:0]        avg_q [AXES];

	logic                    m_tvalid_q;
	logic [OUT_W-1:0]        m_tdata_q;
	logic                    m_tuser_q;

	req_t                    req;
	logic                    fire;
	logic                    out_load;
	logic [LVL_W-1:0]        lvl;
	logic                    ok;
	logic                    take;
	logic signed [SMP_W-1:0] smp [LANES];
	logic                    gyr_good [AXES];
	logic signed [SMP_W-1:0] gyr_use [AXES];
	logic [SENS_W-1:0]       rd_sens;
	logic [LANE_W-1:0]       rd_base;
	logic [CNT_W-1:0]        rd_cnt;
	logic [LANE_W-1:0]       div_lane;
	logic signed [SUM_W-1:0] lane_add;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	// request decode
	always_comb begin
		req  = req_t'(s_tuser);
		lvl  = s_tdata[LVL_W-1:0];
		ok   = s_tdata[LVL_W];
		take = ok && (lvl != '0) && (lvl != last_lvl_q);
		for (int k = 0; k < LANES; k++) begin
			smp[k] = s_tdata[LVL_W + 1 + SMP_W*k +: SMP_W];
		end
		for (int k = 0; k < AXES; k++) begin
			gyr_good[k] = (smp[LANE_GYR + k] >= GYRO_LO) && (smp[LANE_GYR + k] <= GYRO_HI);
			gyr_use[k]  = gyr_good[k] ? smp[LANE_GYR + k] : last_good_q[k];
		end
		case (req)
			REQ_ACC: begin
				rd_sens = SENS_ACC;
				rd_base = LANE_ACC;
			end
			REQ_GYR: begin
				rd_sens = SENS_GYR;
				rd_base = LANE_GYR;
			end
			default: begin
				rd_sens = SENS_TEMP;
				rd_base = LANE_TEMP;
			end
		endcase
		rd_cnt   = cnt_q[rd_sens];
		div_lane = base_q + LANE_W'(axis_q);
		lane_add = sum_q[lane_q] + {{(SUM_W-SMP_W){val_q[lane_q][SMP_W-1]}}, val_q[lane_q]};
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (fire) begin
					if (req == REQ_SAMPLE) begin
						if (take) state_d = ST_ACCUM;
					end else if (rd_cnt != '0) begin
						state_d = ST_DIV;
					end
				end
			end
			ST_ACCUM: begin
				if (lane_q == LANE_LAST) state_d = ST_IDLE;
			end
			ST_DIV: begin
				if (div_rsp.done && (axis_q == last_axis_q)) state_d = ST_OUT;
			end
			ST_OUT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		s_tready         = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
		fire             = s_tvalid && s_tready;
		out_load         = ((state_q == ST_IDLE) && fire && (req != REQ_SAMPLE) && (rd_cnt == '0))
			|| (state_q == ST_OUT);
		cfg_ready        = 1'b1;
		div_req.start    = (state_q == ST_DIV) && !issued_q;
		div_req.dividend = sum_q[div_lane];
		div_req.divisor  = div_cnt_q;
	end

	imu_avg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			time_q     <= TIME_RESET;
			last_lvl_q <= '0;
			add_en_q   <= '0;
			lane_q     <= '0;
			axis_q     <= '0;
			issued_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int k = 0; k < AXES; k++) begin
				last_good_q[k] <= '0;
			end
			for (int k = 0; k < SENSORS; k++) begin
				cnt_q[k] <= '0;
				ids_q[k] <= '0;
			end
			for (int k = 0; k < LANES; k++) begin
				sum_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) time_q <= cfg_data;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (fire && (req == REQ_SAMPLE)) begin
						last_lvl_q <= lvl;
						lane_q     <= '0;
						if (take) begin
							for (int k = 0; k < AXES; k++) begin
								if (gyr_good[k]) last_good_q[k] <= smp[LANE_GYR + k];
							end
							for (int k = 0; k < SENSORS; k++) begin
								if (cnt_q[k] < CNT_MAX) cnt_q[k] <= cnt_q[k] + CNT_W'(1);
							end
							add_en_q <= {{AXES{cnt_q[SENS_GYR] < CNT_MAX}},
								cnt_q[SENS_TEMP] < CNT_MAX,
								{AXES{cnt_q[SENS_ACC] < CNT_MAX}}};
						end
					end else if (fire && (rd_cnt != '0)) begin
						cnt_q[rd_sens] <= '0;
						ids_q[rd_sens] <= ids_q[rd_sens] + ID_W'(1);
						axis_q         <= '0;
						issued_q       <= 1'b0;
					end
				end
				ST_ACCUM: begin
					if (add_en_q[lane_q]) sum_q[lane_q] <= lane_add;
					lane_q <= lane_q + LANE_W'(1);
				end
				ST_DIV: begin
					if (div_req.start) issued_q <= 1'b1;
					if (div_rsp.done) begin
						sum_q[div_lane] <= '0;
						axis_q          <= axis_q + AXIS_W'(1);
						issued_q        <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && fire) begin
			if (req == REQ_SAMPLE) begin
				for (int k = 0; k < AXES; k++) begin
					val_q[LANE_ACC + k] <= smp[LANE_ACC + k];
					val_q[LANE_GYR + k] <= gyr_use[k];
				end
				val_q[LANE_TEMP] <= smp[LANE_TEMP];
			end else if (rd_cnt == '0) begin
				m_tdata_q <= '0;
				m_tuser_q <= 1'b0;
			end else begin
				div_cnt_q   <= rd_cnt;
				base_q      <= rd_base;
				seq_q       <= ids_q[rd_sens] + ID_W'(1);
				last_axis_q <= (req == REQ_TEMP) ? AXIS_W'(0) : AXIS_W'(AXES - 1);
				span_q      <= (req == REQ_TEMP) ? '0 :
					({{(SPAN_W-TIME_W){1'b0}}, time_q} * {{(SPAN_W-CNT_W){1'b0}}, rd_cnt});
				for (int k = 0; k < AXES; k++) begin
					avg_q[k] <= '0;
				end
			end
		end
		if ((state_q == ST_DIV) && div_rsp.done) begin
			avg_q[axis_q] <= div_rsp.quotient;
		end
		if (state_q == ST_OUT) begin
			m_tuser_q <= 1'b1;
			m_tdata_q <= {{(OUT_W - 3*SMP_W - SPAN_W - ID_W){1'b0}},
				seq_q, span_q, avg_q[2], avg_q[1], avg_q[0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### hw/rtl/imu_avg_div.sv
// ----------------------------------------------------------------------------
// imu_avg_div
// shared averaging divider: restoring division, one quotient bit per cycle,
// sum passed through for one sample and floor-halved for two
// ----------------------------------------------------------------------------
module imu_avg_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  imu_avg_pkg::div_req_t req,
	output imu_avg_pkg::div_rsp_t rsp
);
	import imu_avg_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic [CNT_W-1:0]  d_q;
	logic [CNT_W-1:0]  rem_q;
	logic [SUM_W-1:0]  dq_q;
	logic [SMP_W-1:0]  res_q;

	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   trial_sub;
	logic             ge;
	logic [CNT_W-1:0] rem_n;
	logic [SUM_W-1:0] dq_n;
	logic [SUM_W-1:0] mag;
	logic signed [SUM_W-1:0] half;

	always_comb begin
		trial     = {rem_q, dq_q[SUM_W-1]};
		ge        = trial >= {1'b0, d_q};
		trial_sub = trial - {1'b0, d_q};
		rem_n     = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
		dq_n      = {dq_q[SUM_W-2:0], ge};
		mag       = req.dividend[SUM_W-1] ? (-req.dividend) : req.dividend;
		half      = req.dividend >>> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !run_q) begin
				if (req.divisor == CNT_W'(1)) begin
					done_q <= 1'b1;
				end else if (req.divisor == CNT_W'(2)) begin
					done_q <= 1'b1;
				end else begin
					run_q  <= 1'b1;
					step_q <= '0;
				end
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !run_q) begin
			neg_q <= req.dividend[SUM_W-1];
			d_q   <= req.divisor;
			rem_q <= '0;
			dq_q  <= mag;
			if (req.divisor == CNT_W'(1)) begin
				res_q <= req.dividend[SMP_W-1:0];
			end else if (req.divisor == CNT_W'(2)) begin
				res_q <= half[SMP_W-1:0];
			end
		end else if (run_q) begin
			rem_q <= rem_n;
			dq_q  <= dq_n;
			if (step_q == STEP_LAST) begin
				res_q <= neg_q ? (-dq_n[SMP_W-1:0]) : dq_n[SMP_W-1:0];
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = res_q;

endmodule

### hw/rtl/imu_avg_chk.sv
// ----------------------------------------------------------------------------
// imu_avg_chk
// port-level checks on the averager, bound to the top level
// ----------------------------------------------------------------------------
module imu_avg_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [imu_avg_pkg::IN_W-1:0]   s_tdata,
	input logic [imu_avg_pkg::REQ_W-1:0]  s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [imu_avg_pkg::OUT_W-1:0]  m_tdata,
	input logic                           m_tuser,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [imu_avg_pkg::TIME_W-1:0] cfg_data
);

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// an empty readout carries all-zero fields
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("empty readout with nonzero fields");

	// no new request while a result is stuck
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request taken while result pending");

	// the configuration channel never stalls
	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind imu_sample_averager_core imu_avg_chk u_imu_avg_chk (.*);
